>>> sv/pwfp_pkg.sv
`default_nettype none

package pwfp_pkg;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_TAG   = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DROP  = 5'b10000
    } phase_t;

    // Result event codes.
    localparam logic [2:0] EV_VARINT  = 3'd0;
    localparam logic [2:0] EV_FIXED64 = 3'd1;
    localparam logic [2:0] EV_LENGTH  = 3'd2;
    localparam logic [2:0] EV_FIXED32 = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;
    localparam logic [2:0] EV_BADWIRE = 3'd5;
    localparam logic [2:0] EV_TRUNC   = 3'd6;

    // Wire types that the parser accepts.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // One result item, with its valid flag.
    typedef struct packed {
        logic        valid;
        logic [2:0]  evt;
        logic [31:0] fnum;
        logic [2:0]  wkind;
        logic [63:0] value;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

>>> sv/pwfp_step.sv
`default_nettype none

module pwfp_step
    import pwfp_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = 10,
    parameter int LENGTH_WIDTH     = 32
) (
    input  wire phase_t             phase,
    input  wire logic [63:0]        acc,
    input  wire logic [3:0]         cnt,
    input  wire logic [31:0]        fnum,
    input  wire logic [2:0]         wtype,
    input  wire logic [LENGTH_WIDTH-1:0] skip,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output phase_t                  phase_next,
    output logic [63:0]             acc_next,
    output logic [3:0]              cnt_next,
    output logic [31:0]             fnum_next,
    output logic [2:0]              wtype_next,
    output logic [LENGTH_WIDTH-1:0] skip_next,
    output res_t                    res
);

    logic [6:0]              sh7;
    logic [5:0]              sh;
    logic [63:0]             acc_upd;
    logic [3:0]              cnt_inc;
    logic                    vdone;
    logic [31:0]             fnum_dec;
    logic [2:0]              wtype_dec;
    logic                    len_big;
    logic [LENGTH_WIDTH-1:0] skip_dec;

    // Varint accumulation: seven payload bits per byte at offset 7 * count.
    assign sh7       = {cnt, 3'b000} - {3'b000, cnt};
    assign sh        = sh7[5:0];
    assign acc_upd   = acc | ({57'd0, data_byte[6:0]} << sh);
    assign cnt_inc   = cnt + 4'd1;
    assign vdone     = !data_byte[7] || (cnt_inc >= 4'(MAX_VARINT_BYTES));
    assign fnum_dec  = acc_upd[34:3];
    assign wtype_dec = acc_upd[2:0];
    assign len_big   = (acc_upd >> LENGTH_WIDTH) != 64'd0;
    assign skip_dec  = skip - LENGTH_WIDTH'(1);

    // Next state and result for one byte.
    always_comb
    begin
        phase_next = phase;
        acc_next   = acc;
        cnt_next   = cnt;
        fnum_next  = fnum;
        wtype_next = wtype;
        skip_next  = skip;
        res.valid  = 1'b0;
        res.evt    = EV_TRUNC;
        res.fnum   = fnum;
        res.wkind  = wtype;
        res.value  = 64'd0;
        res.last   = last_byte;

        case (phase)
            PH_TAG, PH_VALUE, PH_LEN:
            begin
                acc_next = acc_upd;
                cnt_next = cnt_inc;
                if (!vdone)
                begin
                    // A varint cut off by the end of the buffer.
                    if (last_byte)
                    begin
                        res.valid = 1'b1;
                        res.evt   = EV_TRUNC;
                        if (phase == PH_TAG)
                        begin
                            res.fnum  = 32'd0;
                            res.wkind = 3'd0;
                        end
                    end
                end
                else if (phase == PH_TAG)
                begin
                    fnum_next  = fnum_dec;
                    wtype_next = wtype_dec;
                    acc_next   = 64'd0;
                    cnt_next   = 4'd0;
                    res.fnum   = fnum_dec;
                    res.wkind  = wtype_dec;
                    if (fnum_dec == 32'd0)
                    begin
                        res.valid  = 1'b1;
                        res.evt    = EV_END;
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        case (wtype_dec)
                            WT_VARINT:  phase_next = PH_VALUE;
                            WT_LENGTH:  phase_next = PH_LEN;
                            WT_FIXED64:
                            begin
                                phase_next = PH_SKIP;
                                skip_next  = LENGTH_WIDTH'(8);
                            end
                            WT_FIXED32:
                            begin
                                phase_next = PH_SKIP;
                                skip_next  = LENGTH_WIDTH'(4);
                            end
                            default:
                            begin
                                res.valid  = 1'b1;
                                res.evt    = EV_BADWIRE;
                                phase_next = PH_DROP;
                            end
                        endcase
                        // A tag whose payload never arrives.
                        if (!res.valid && last_byte)
                        begin
                            res.valid = 1'b1;
                            res.evt   = EV_TRUNC;
                        end
                    end
                end
                else if (phase == PH_VALUE)
                begin
                    res.valid  = 1'b1;
                    res.evt    = EV_VARINT;
                    res.value  = acc_upd;
                    acc_next   = 64'd0;
                    cnt_next   = 4'd0;
                    phase_next = PH_TAG;
                end
                else
                begin
                    // Length varint done; the accumulator keeps the length.
                    cnt_next = 4'd0;
                    if (len_big)
                    begin
                        res.valid  = 1'b1;
                        res.evt    = EV_TRUNC;
                        phase_next = PH_DROP;
                    end
                    else if (acc_upd == 64'd0)
                    begin
                        res.valid  = 1'b1;
                        res.evt    = EV_LENGTH;
                        acc_next   = 64'd0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        skip_next  = acc_upd[LENGTH_WIDTH-1:0];
                        phase_next = PH_SKIP;
                        if (last_byte)
                        begin
                            res.valid = 1'b1;
                            res.evt   = EV_TRUNC;
                        end
                    end
                end
            end

            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == LENGTH_WIDTH'(0))
                begin
                    res.valid  = 1'b1;
                    acc_next   = 64'd0;
                    phase_next = PH_TAG;
                    if (wtype == WT_LENGTH)
                    begin
                        res.evt   = EV_LENGTH;
                        res.wkind = WT_LENGTH;
                        res.value = acc;
                    end
                    else if (wtype == WT_FIXED64)
                    begin
                        res.evt   = EV_FIXED64;
                        res.wkind = WT_FIXED64;
                    end
                    else
                    begin
                        res.evt = EV_FIXED32;
                    end
                end
                else if (last_byte)
                begin
                    res.valid = 1'b1;
                    res.evt   = EV_TRUNC;
                end
            end

            default:
            begin
                // Dropping bytes until the end of the buffer.
            end
        endcase

        // The last byte of a buffer returns the parser to its start state.
        if (last_byte)
        begin
            phase_next = PH_TAG;
            acc_next   = 64'd0;
            cnt_next   = 4'd0;
            fnum_next  = 32'd0;
            wtype_next = 3'd0;
            skip_next  = '0;
        end
    end

endmodule

`default_nettype wire

>>> sv/protobuf_wire_field_parser_core.sv
`default_nettype none

// Protobuf wire-format field parser. Message bytes enter on the input channel
// one per transfer, with last_byte marking the end of each buffer; each byte
// yields zero or one result, which appears on the output channel in the cycle
// after the byte is taken. The parser takes one byte every cycle: the whole
// per-byte update (varint shift-or, tag decode, skip count) is combinational
// from the state registers to the result register, and the input is held
// off only while a result waits in that register and out_ready is low.
module protobuf_wire_field_parser_core
    import pwfp_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = 10,
    parameter int LENGTH_WIDTH     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_res,
    output logic [31:0]      field_num,
    output logic [2:0]       wire_kind,
    output logic [63:0]      field_value,
    output logic             buffer_end
);

    phase_t                  phase_reg, phase_next;
    logic [63:0]             acc_reg, acc_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [31:0]             fnum_reg, fnum_next;
    logic [2:0]              wtype_reg, wtype_next;
    logic [LENGTH_WIDTH-1:0] skip_reg, skip_next;
    res_t                    res;
    logic                    out_valid_reg;
    res_t                    out_reg;
    logic                    in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Per-byte parser logic.
    pwfp_step #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .LENGTH_WIDTH     (LENGTH_WIDTH)
    ) u_step (
        .phase      (phase_reg),
        .acc        (acc_reg),
        .cnt        (cnt_reg),
        .fnum       (fnum_reg),
        .wtype      (wtype_reg),
        .skip       (skip_reg),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .phase_next (phase_next),
        .acc_next   (acc_next),
        .cnt_next   (cnt_next),
        .fnum_next  (fnum_next),
        .wtype_next (wtype_next),
        .skip_next  (skip_next),
        .res        (res)
    );

    // Parser state advances on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg   <= 64'd0;
            cnt_reg   <= 4'd0;
            fnum_reg  <= 32'd0;
            wtype_reg <= 3'd0;
            skip_reg  <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            fnum_reg  <= fnum_next;
            wtype_reg <= wtype_next;
            skip_reg  <= skip_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = out_reg.evt;
    assign field_num   = out_reg.fnum;
    assign wire_kind   = out_reg.wkind;
    assign field_value = out_reg.value;
    assign buffer_end  = out_reg.last;

endmodule

`default_nettype wire
